### sv/top_k_smallest_distance_list_assert.svh
// Assertion macros shared by the top-k distance list RTL
`ifndef TOP_K_SMALLEST_DISTANCE_LIST_ASSERT_SVH
`define TOP_K_SMALLEST_DISTANCE_LIST_ASSERT_SVH

// same-cycle implication
`define TKSDL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tksdl assertion failed");

// next-cycle implication
`define TKSDL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tksdl assertion failed");

`endif

### sv/tksdl_pkg.sv
// Shared types and constants for the top-k distance list
package tksdl_pkg;

   localparam int FieldW = 32;
   localparam int CmdW   = 2;
   localparam int PosW   = 3;
   localparam int CountW = 4;
   localparam int CapW   = 4;

   localparam logic [CapW-1:0] CapReset = 4'd8;

   typedef enum logic [CmdW-1:0] {
      CMD_ADD   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_DUMP  = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic              add;
      logic              rotate;
      logic [FieldW-1:0] cand_id;
      logic [FieldW-1:0] cand_dist;
   } cell_ctrl_type;

endpackage

### sv/tksdl_cell.sv
// One list cell: holds a ranked entry, shifts on insert, rotates on dump
module tksdl_cell (
   input  logic                          clock,
   input  tksdl_pkg::cell_ctrl_type      ctrl,
   input  logic                          occupied,
   input  logic                          is_tail,
   input  logic                          append,
   input  logic                          prev_larger,
   input  logic [tksdl_pkg::FieldW-1:0]  prev_id,
   input  logic [tksdl_pkg::FieldW-1:0]  prev_dist,
   input  logic [tksdl_pkg::FieldW-1:0]  next_id,
   input  logic [tksdl_pkg::FieldW-1:0]  next_dist,
   input  logic [tksdl_pkg::FieldW-1:0]  head_id,
   input  logic [tksdl_pkg::FieldW-1:0]  head_dist,
   output logic                          larger,
   output logic [tksdl_pkg::FieldW-1:0]  id,
   output logic [tksdl_pkg::FieldW-1:0]  entry_dist
);

   logic [tksdl_pkg::FieldW-1:0] id_ff, id_in;
   logic [tksdl_pkg::FieldW-1:0] dist_ff, dist_in;

   // strict compare keeps ties in arrival order
   assign larger     = occupied && (ctrl.cand_dist < dist_ff);
   assign id         = id_ff;
   assign entry_dist = dist_ff;

   always_comb begin
      id_in   = id_ff;
      dist_in = dist_ff;
      if (ctrl.add) begin
         if (prev_larger) begin
            id_in   = prev_id;
            dist_in = prev_dist;
         end else if (larger || append) begin
            id_in   = ctrl.cand_id;
            dist_in = ctrl.cand_dist;
         end
      end else if (ctrl.rotate) begin
         // tail wraps to the head so a full pass restores the order
         if (is_tail) begin
            id_in   = head_id;
            dist_in = head_dist;
         end else begin
            id_in   = next_id;
            dist_in = next_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      dist_ff <= dist_in;
   end

endmodule

### sv/top_k_smallest_distance_list.sv
// Top level of the top-k smallest distance list: cell chain plus control
//
//   channel | direction | fields
//   req     | in        | command, cand_index, cand_distance
//   rsp     | out       | entry_valid, position, out_index, out_distance,
//           |           | inserted, entry_count, is_full, last
//   csr     | in        | capacity
//
// Add, clear and unused codes each give one result; an item can enter every cycle
// while the result register drains. A dump of a filled list gives one result per stored
// entry, reading the head cell while the chain rotates by one. Synchronous reset empties
// the list and sets capacity to 8. A stalled result holds the req side off.
`include "top_k_smallest_distance_list_assert.svh"

module top_k_smallest_distance_list #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tksdl_pkg::CmdW-1:0]     req_command,
   input  logic [tksdl_pkg::FieldW-1:0]   req_cand_index,
   input  logic [tksdl_pkg::FieldW-1:0]   req_cand_distance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_entry_valid,
   output logic [tksdl_pkg::PosW-1:0]     rsp_position,
   output logic [tksdl_pkg::FieldW-1:0]   rsp_out_index,
   output logic [tksdl_pkg::FieldW-1:0]   rsp_out_distance,
   output logic                           rsp_inserted,
   output logic [tksdl_pkg::CountW-1:0]   rsp_entry_count,
   output logic                           rsp_is_full,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tksdl_pkg::CapW-1:0]     csr_capacity
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   function automatic logic [CW-1:0] eff_cap(input logic [tksdl_pkg::CapW-1:0] cap);
      logic [CW-1:0] res;
      if (cap == '0) res = CW'(1);
      else if (32'(cap) > 32'(MAX_ENTRIES)) res = CW'(MAX_ENTRIES);
      else res = CW'(cap);
      return res;
   endfunction

   tksdl_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [tksdl_pkg::CapW-1:0] cap_ff, cap_in;
   logic [IW-1:0]            rank_ff, rank_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          ent_valid_ff, ent_valid_in;
   logic [tksdl_pkg::PosW-1:0]    pos_ff, pos_in;
   logic [tksdl_pkg::FieldW-1:0]  idx_ff, idx_in;
   logic [tksdl_pkg::FieldW-1:0]  dist_ff, dist_in;
   logic                          ins_ff, ins_in;
   logic [tksdl_pkg::CountW-1:0]  cnt_ff, cnt_in;
   logic                          full_ff, full_in;
   logic                          last_ff, last_in;

   tksdl_pkg::cell_ctrl_type ctrl;
   tksdl_pkg::cmd_type       cmd;

   logic [MAX_ENTRIES-1:0]        larger;
   logic [tksdl_pkg::FieldW-1:0]  cell_id   [MAX_ENTRIES];
   logic [tksdl_pkg::FieldW-1:0]  cell_dist [MAX_ENTRIES];

   logic [CW-1:0] cap_eff, cap_new;
   logic          out_free, req_fire, any_larger, has_room, dump_tail;
   logic [IW-1:0] ins_pos;

   assign cmd       = tksdl_pkg::cmd_type'(req_command);
   assign cap_eff   = eff_cap(cap_ff);
   assign cap_new   = eff_cap(csr_capacity);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == tksdl_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign any_larger = |larger;
   assign has_room  = count_ff < cap_eff;
   assign dump_tail = (CW'(rank_ff) + CW'(1)) == count_ff;

   // cell chain
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                         p_larger;
      logic [tksdl_pkg::FieldW-1:0] p_id, p_dist, n_id, n_dist;
      if (i == 0) begin : g_first
         assign p_larger = 1'b0;
         assign p_id     = '0;
         assign p_dist   = '0;
      end else begin : g_mid
         assign p_larger = larger[i-1];
         assign p_id     = cell_id[i-1];
         assign p_dist   = cell_dist[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign n_id   = cell_id[0];
         assign n_dist = cell_dist[0];
      end else begin : g_nxt
         assign n_id   = cell_id[i+1];
         assign n_dist = cell_dist[i+1];
      end

      tksdl_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CW'(i) < count_ff),
         .is_tail     (CW'(i + 1) == count_ff),
         .append      (!any_larger && has_room && (CW'(i) == count_ff)),
         .prev_larger (p_larger),
         .prev_id     (p_id),
         .prev_dist   (p_dist),
         .next_id     (n_id),
         .next_dist   (n_dist),
         .head_id     (cell_id[0]),
         .head_dist   (cell_dist[0]),
         .larger      (larger[i]),
         .id          (cell_id[i]),
         .entry_dist  (cell_dist[i])
      );
   end

   // insertion rank: first larger cell, else the end of the list
   always_comb begin
      ins_pos = count_ff[IW-1:0];
      if (any_larger) begin
         ins_pos = '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (larger[i] && (i == 0 || !larger[(i == 0) ? 0 : i - 1])) begin
               ins_pos = ins_pos | IW'(i);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tksdl_pkg::ST_IDLE: begin
            if (req_fire && cmd == tksdl_pkg::CMD_DUMP && count_ff != '0) begin
               state_in = tksdl_pkg::ST_DUMP;
            end
         end
         tksdl_pkg::ST_DUMP: begin
            if (out_free && dump_tail) state_in = tksdl_pkg::ST_IDLE;
         end
         default: state_in = tksdl_pkg::ST_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      ctrl           = '0;
      ctrl.cand_id   = req_cand_index;
      ctrl.cand_dist = req_cand_distance;
      count_in       = count_ff;
      cap_in         = cap_ff;
      rank_in        = rank_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ent_valid_in   = ent_valid_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      dist_in        = dist_ff;
      ins_in         = ins_ff;
      last_in        = last_ff;

      if (csr_valid) begin
         cap_in = csr_capacity;
         if (count_ff > cap_new) count_in = cap_new;
      end

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         ent_valid_in = 1'b0;
         pos_in       = '0;
         idx_in       = '0;
         dist_in      = '0;
         ins_in       = 1'b0;
         last_in      = 1'b1;
         case (cmd)
            tksdl_pkg::CMD_ADD: begin
               if (any_larger || has_room) begin
                  ctrl.add = 1'b1;
                  ins_in   = 1'b1;
                  pos_in   = tksdl_pkg::PosW'(ins_pos);
                  if (has_room) count_in = count_ff + CW'(1);
               end
            end
            tksdl_pkg::CMD_CLEAR: count_in = '0;
            tksdl_pkg::CMD_DUMP: begin
               if (count_ff != '0) begin
                  rsp_valid_in = 1'b0;
                  rank_in      = '0;
               end
            end
            default: ;
         endcase
      end

      if (state_ff == tksdl_pkg::ST_DUMP && out_free) begin
         ctrl.rotate  = 1'b1;
         rsp_valid_in = 1'b1;
         ent_valid_in = 1'b1;
         pos_in       = tksdl_pkg::PosW'(rank_ff);
         idx_in       = cell_id[0];
         dist_in      = cell_dist[0];
         ins_in       = 1'b0;
         last_in      = dump_tail;
         rank_in      = rank_ff + IW'(1);
      end
   end

   assign cnt_in  = tksdl_pkg::CountW'(count_in);
   assign full_in = count_in >= cap_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tksdl_pkg::ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= tksdl_pkg::CapReset;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in && out_free) begin
         ent_valid_ff <= ent_valid_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         dist_ff      <= dist_in;
         ins_ff       <= ins_in;
         cnt_ff       <= cnt_in;
         full_ff      <= full_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = ent_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_out_index    = idx_ff;
   assign rsp_out_distance = dist_ff;
   assign rsp_inserted     = ins_ff;
   assign rsp_entry_count  = cnt_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_last         = last_ff;

   `TKSDL_ASSERT_NOW(a_count_le_cap, clock, reset, 1'b1, count_ff <= cap_eff)
   `TKSDL_ASSERT_NEXT(a_single_result, clock, reset,
      req_fire && cmd != tksdl_pkg::CMD_DUMP, rsp_valid_ff && rsp_last)
   `TKSDL_ASSERT_NEXT(a_dump_ends, clock, reset,
      state_ff == tksdl_pkg::ST_DUMP && out_free && dump_tail,
      state_ff == tksdl_pkg::ST_IDLE && rsp_last && rsp_entry_valid)
   `TKSDL_ASSERT_NEXT(a_reject_holds, clock, reset,
      req_fire && cmd == tksdl_pkg::CMD_ADD && !any_larger && !has_room,
      $stable(count_ff) && !rsp_inserted)

endmodule

### sim/tb_top_k_smallest_distance_list.sv
// Self-checking testbench for the top-k smallest distance list
module tb_top_k_smallest_distance_list;

   localparam int Depth      = 8;
   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 41;
   localparam logic [tksdl_pkg::CmdW-1:0] CmdUnused = 2'd3;

   typedef struct {
      logic                         entry_valid;
      logic [tksdl_pkg::PosW-1:0]   position;
      logic [tksdl_pkg::FieldW-1:0] index;
      logic [tksdl_pkg::FieldW-1:0] distance;
      logic                         inserted;
      logic [tksdl_pkg::CountW-1:0] count;
      logic                         full;
      logic                         last;
   } list_report_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [tksdl_pkg::CmdW-1:0]   req_command = tksdl_pkg::CMD_ADD;
   logic [tksdl_pkg::FieldW-1:0] req_cand_index = '0;
   logic [tksdl_pkg::FieldW-1:0] req_cand_distance = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_entry_valid;
   logic [tksdl_pkg::PosW-1:0]   rsp_position;
   logic [tksdl_pkg::FieldW-1:0] rsp_out_index;
   logic [tksdl_pkg::FieldW-1:0] rsp_out_distance;
   logic                         rsp_inserted;
   logic [tksdl_pkg::CountW-1:0] rsp_entry_count;
   logic                         rsp_is_full;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [tksdl_pkg::CapW-1:0]   csr_capacity = tksdl_pkg::CapReset;

   // shadow copy of the sorted list
   logic [tksdl_pkg::FieldW-1:0] list_ids [Depth];
   logic [tksdl_pkg::FieldW-1:0] list_dists [Depth];
   int                           list_count = 0;
   logic [tksdl_pkg::CapW-1:0]   list_cap = tksdl_pkg::CapReset;
   list_report_type              pending_reports [$];

   int                  errors = 0;
   int                  cycles = 0;
   bit                  no_idle = 1'b0;

   top_k_smallest_distance_list #(
      .MAX_ENTRIES(Depth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_cand_index(req_cand_index),
      .req_cand_distance(req_cand_distance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_position(rsp_position),
      .rsp_out_index(rsp_out_index),
      .rsp_out_distance(rsp_out_distance),
      .rsp_inserted(rsp_inserted),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_full(rsp_is_full),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity(csr_capacity)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 18);
   end

   // zero and out-of-range capacities are clamped
   function automatic int limit_of_list();
      if (list_cap == 0) return 1;
      if (list_cap > Depth) return Depth;
      return int'(list_cap);
   endfunction

   function automatic list_report_type make_report(input logic ev, input int pos,
         input logic [tksdl_pkg::FieldW-1:0] idx, input logic [tksdl_pkg::FieldW-1:0] cand_dist,
         input logic ins, input logic fin);
      list_report_type r;
      r.entry_valid = ev;
      r.position    = pos[tksdl_pkg::PosW-1:0];
      r.index       = idx;
      r.distance    = cand_dist;
      r.inserted    = ins;
      r.count       = list_count[tksdl_pkg::CountW-1:0];
      r.full        = (list_count >= limit_of_list());
      r.last        = fin;
      return r;
   endfunction

   function automatic void apply_list_command(input logic [tksdl_pkg::CmdW-1:0] cmd,
         input logic [tksdl_pkg::FieldW-1:0] idx, input logic [tksdl_pkg::FieldW-1:0] cand_dist);
      int slot;
      int cap;
      cap = limit_of_list();
      case (cmd)
         tksdl_pkg::CMD_ADD: begin
            // first entry with a strictly larger distance; ties keep arrival order
            slot = list_count;
            for (int i = list_count - 1; i >= 0; i--)
               if (cand_dist < list_dists[i]) slot = i;
            if (slot >= list_count && list_count >= cap) begin
               pending_reports.push_back(make_report(1'b0, 0, '0, '0, 1'b0, 1'b1));
            end else begin
               if (list_count < cap) list_count++;
               for (int i = list_count - 1; i > slot; i--) begin
                  list_ids[i]   = list_ids[i-1];
                  list_dists[i] = list_dists[i-1];
               end
               list_ids[slot]   = idx;
               list_dists[slot] = cand_dist;
               pending_reports.push_back(make_report(1'b0, slot, '0, '0, 1'b1, 1'b1));
            end
         end
         tksdl_pkg::CMD_CLEAR: begin
            list_count = 0;
            pending_reports.push_back(make_report(1'b0, 0, '0, '0, 1'b0, 1'b1));
         end
         tksdl_pkg::CMD_DUMP: begin
            if (list_count == 0)
               pending_reports.push_back(make_report(1'b0, 0, '0, '0, 1'b0, 1'b1));
            for (int i = 0; i < list_count; i++)
               pending_reports.push_back(make_report(1'b1, i, list_ids[i], list_dists[i],
                                                     1'b0, i == list_count - 1));
         end
         default: begin
            pending_reports.push_back(make_report(1'b0, 0, '0, '0, 1'b0, 1'b1));
         end
      endcase
   endfunction

   function automatic void check_field(input string name,
         input logic [tksdl_pkg::FieldW-1:0] want, input logic [tksdl_pkg::FieldW-1:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      list_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("result with nothing expected, entry_count %0d", rsp_entry_count);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            check_field("entry_valid", tksdl_pkg::FieldW'(want.entry_valid),
                        tksdl_pkg::FieldW'(rsp_entry_valid));
            check_field("position", tksdl_pkg::FieldW'(want.position),
                        tksdl_pkg::FieldW'(rsp_position));
            check_field("out_index", want.index, rsp_out_index);
            check_field("out_distance", want.distance, rsp_out_distance);
            check_field("inserted", tksdl_pkg::FieldW'(want.inserted),
                        tksdl_pkg::FieldW'(rsp_inserted));
            check_field("entry_count", tksdl_pkg::FieldW'(want.count),
                        tksdl_pkg::FieldW'(rsp_entry_count));
            check_field("is_full", tksdl_pkg::FieldW'(want.full),
                        tksdl_pkg::FieldW'(rsp_is_full));
            check_field("last", tksdl_pkg::FieldW'(want.last),
                        tksdl_pkg::FieldW'(rsp_last));
         end
      end
   end

   task automatic send_item(input logic [tksdl_pkg::CmdW-1:0] cmd,
         input logic [tksdl_pkg::FieldW-1:0] idx, input logic [tksdl_pkg::FieldW-1:0] cand_dist);
      int gap;
      gap = 0;
      while (!no_idle && $urandom_range(99) < 18) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_cand_index    <= idx;
      req_cand_distance <= cand_dist;
      do @(posedge clock); while (!req_ready);
      apply_list_command(cmd, idx, cand_dist);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [tksdl_pkg::CapW-1:0] value);
      wait_drained();
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      list_cap = value;
      // lowering the capacity drops the largest entries
      if (list_count > limit_of_list()) list_count = limit_of_list();
   endtask

   task automatic test_reset_state();
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
      send_item(CmdUnused, '1, '1);
   endtask

   task automatic test_add_order();
      send_item(tksdl_pkg::CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(tksdl_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(tksdl_pkg::CMD_ADD, 32'h0000_0005, 32'h0000_0100);
      send_item(tksdl_pkg::CMD_ADD, 32'h0000_0006, 32'h0000_0100);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
   endtask

   task automatic test_full_list();
      send_item(tksdl_pkg::CMD_CLEAR, '0, '0);
      write_capacity(4'd3);
      send_item(tksdl_pkg::CMD_ADD, 32'd1, 32'd50);
      send_item(tksdl_pkg::CMD_ADD, 32'd2, 32'd10);
      send_item(tksdl_pkg::CMD_ADD, 32'd3, 32'd30);
      send_item(tksdl_pkg::CMD_ADD, 32'd4, 32'd60);
      send_item(tksdl_pkg::CMD_ADD, 32'd5, 32'd50);
      send_item(tksdl_pkg::CMD_ADD, 32'd6, 32'd20);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(4'd15);
      // middle insertion into a list with room must grow the count
      send_item(tksdl_pkg::CMD_ADD, 32'd7, 32'd25);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
      write_capacity(4'd2);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
      write_capacity(4'd0);
      send_item(tksdl_pkg::CMD_ADD, 32'd10, 32'd0);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
   endtask

   task automatic test_clear();
      send_item(tksdl_pkg::CMD_CLEAR, '1, '1);
      send_item(tksdl_pkg::CMD_DUMP, '0, '0);
      send_item(tksdl_pkg::CMD_ADD, 32'h1234_5678, 32'd7);
   endtask

   task automatic send_random_item();
      int pick;
      logic [tksdl_pkg::CmdW-1:0] cmd;
      logic [tksdl_pkg::FieldW-1:0] cand_dist;
      pick = $urandom_range(99);
      if (pick < 70) cmd = tksdl_pkg::CMD_ADD;
      else if (pick < 84) cmd = tksdl_pkg::CMD_DUMP;
      else if (pick < 93) cmd = tksdl_pkg::CMD_CLEAR;
      else cmd = CmdUnused;
      // narrow distances most of the time so ties and middle inserts are common
      case ($urandom_range(9))
         0: cand_dist = $urandom;
         1: cand_dist = $urandom_range(1) ? '1 : '0;
         default: cand_dist = $urandom_range(31);
      endcase
      send_item(cmd, $urandom, cand_dist);
   endtask

   task automatic test_random_traffic();
      logic [tksdl_pkg::CapW-1:0] caps [10];
      caps = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd2, 4'd6, 4'd8, 4'd5, 4'd3};
      for (int p = 0; p < 10; p++) begin
         write_capacity(caps[p]);
         no_idle = (p == 6);
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 3 && n == 20) wait_drained();
            send_random_item();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_add_order();
      test_full_list();
      test_capacity_limits();
      test_clear();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/tksdl_pkg.sv
sv/tksdl_cell.sv
sv/top_k_smallest_distance_list.sv
sim/tb_top_k_smallest_distance_list.sv
